@@ rtl/core/mtdm_pkg.sv @@
`default_nettype none

package mtdm_pkg;

    // Sizing
    localparam int MAX_PIXELS    = 8192;
    localparam int MAX_TEMPLATES = 16;
    localparam int COUNT_CAP     = 16383;
    localparam int COUNT_LIMIT   = (MAX_PIXELS < COUNT_CAP) ? MAX_PIXELS : COUNT_CAP;
    localparam int TMPL_LAST     = ((MAX_TEMPLATES < 16) ? MAX_TEMPLATES : 16) - 1;

    localparam int COUNT_W = 14;
    localparam int SUM_W   = 27;
    localparam int DIST_W  = 13;
    localparam int TMPL_W  = 4;
    localparam int SQ_W    = 18;
    localparam int REM_W   = 16;
    localparam int STEP_W  = 5;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    // Iteration counts of the shift/subtract unit
    localparam int SQRT_STEPS = 13;
    localparam int DIV_STEPS  = 27;

    typedef enum logic
    {
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_TEMPLATE,
        ST_DIV_WAIT,
        ST_TEMPLATE_DONE,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic [7:0] image_red;
        logic [7:0] image_green;
        logic [7:0] image_blue;
        logic [7:0] pattern_red;
        logic [7:0] pattern_green;
        logic [7:0] pattern_blue;
        logic       mask_weight;
        logic       inside_image;
        logic       window_rejected;
        logic       template_end;
        logic       center_end;
    } pix_t;

    typedef struct packed
    {
        logic [DIST_W-1:0] best_distance;
        logic [TMPL_W-1:0] best_template;
        logic              found;
        logic              is_match;
    } res_t;

    // Sequencer to shared unit
    typedef struct packed
    {
        logic             start;
        op_t              op;
        logic [SUM_W-1:0] operand;
        logic [COUNT_W-1:0] divisor;
    } unit_req_t;

    // Shared unit back to sequencer
    typedef struct packed
    {
        logic             done;
        logic [SUM_W-1:0] result;
    } unit_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/masked_template_distance_min.sv @@
`default_nettype none

// Channel  Direction  Handshake              Beat
// pix      in         pix_valid/pix_ready    mtdm_pkg::pix_t, one pixel pair
// res      out        res_valid/res_ready    mtdm_pkg::res_t, one per centre
// cfg      in         cfg_valid/cfg_ready    13-bit match threshold
//
// A counted pixel is accepted, squared channel by channel on the one
// 8x8 multiplier, launched into the shared unit for the 13-bit square
// root, and then has its template flags checked. A skipped pixel goes straight to the check.
// A template end then runs the 27-step division on the same unit
// and closes the template; a rejected or empty template only closes it.
// A centre end then loads the result register; it waits there
// only if the previous result has not been taken.
// Reset: asynchronous, clears threshold, template and centre state.
module masked_template_distance_min
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pix_valid,
    output logic                            pix_ready,
    input  wire mtdm_pkg::pix_t             pix,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output mtdm_pkg::res_t                  res,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mtdm_pkg::DIST_W-1:0] cfg_data
);

    mtdm_pkg::state_t               state_reg, state_next;
    mtdm_pkg::pix_t                 item_reg, item_next;
    logic [1:0]                     ch_reg, ch_next;
    logic [mtdm_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic [mtdm_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [mtdm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           rej_reg, rej_next;
    logic [mtdm_pkg::TMPL_W-1:0]    tmpl_reg, tmpl_next;
    logic [mtdm_pkg::DIST_W-1:0]    best_reg, best_next;
    logic [mtdm_pkg::TMPL_W-1:0]    best_idx_reg, best_idx_next;
    logic                           found_reg, found_next;
    logic [mtdm_pkg::DIST_W-1:0]    thr_reg;
    mtdm_pkg::res_t                 res_reg, res_next;
    logic                           res_valid_reg, res_valid_next;

    mtdm_pkg::unit_req_t            req;
    mtdm_pkg::unit_rsp_t            rsp;

    logic [7:0]                     ch_a, ch_b, ch_diff;
    logic [15:0]                    ch_sq;
    logic [mtdm_pkg::DIST_W-1:0]    mean_dist;

    mtdm_shsub u_shsub
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Channel select and squared difference
    always_comb
    begin
        unique case (ch_reg)
            2'd0:
            begin
                ch_a = item_reg.image_red;
                ch_b = item_reg.pattern_red;
            end
            2'd1:
            begin
                ch_a = item_reg.image_green;
                ch_b = item_reg.pattern_green;
            end
            default:
            begin
                ch_a = item_reg.image_blue;
                ch_b = item_reg.pattern_blue;
            end
        endcase
        ch_diff = (ch_a >= ch_b) ? (ch_a - ch_b) : (ch_b - ch_a);
        ch_sq   = ch_diff * ch_diff;
    end

    // Quotient clamped to the distance range
    assign mean_dist = (rsp.result > mtdm_pkg::SUM_W'(mtdm_pkg::DIST_NONE))
                     ? mtdm_pkg::DIST_NONE : rsp.result[mtdm_pkg::DIST_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        ch_next        = ch_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        rej_next       = rej_reg;
        tmpl_next      = tmpl_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        pix_ready      = 1'b0;
        req.start      = 1'b0;
        req.op         = mtdm_pkg::OP_SQRT;
        req.operand    = {sq_reg, 9'd0};
        req.divisor    = count_reg;

        unique case (state_reg)
            mtdm_pkg::ST_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    item_next = pix;
                    rej_next  = rej_reg | pix.window_rejected;
                    ch_next   = 2'd0;
                    sq_next   = '0;
                    if (pix.inside_image &&
                        (count_reg < mtdm_pkg::COUNT_W'(mtdm_pkg::COUNT_LIMIT)))
                        state_next = mtdm_pkg::ST_SQUARE;
                    else
                        state_next = mtdm_pkg::ST_TEMPLATE;
                end
            end
            mtdm_pkg::ST_SQUARE:
            begin
                sq_next = sq_reg + mtdm_pkg::SQ_W'(ch_sq);
                ch_next = ch_reg + 1'b1;
                if (ch_reg == 2'd2)
                    state_next = mtdm_pkg::ST_ROOT_GO;
            end
            mtdm_pkg::ST_ROOT_GO:
            begin
                // radicand is sq << 8, aligned to the top of the operand
                req.start  = 1'b1;
                req.op     = mtdm_pkg::OP_SQRT;
                req.operand = {sq_reg, 9'd0};
                state_next = mtdm_pkg::ST_ROOT_WAIT;
            end
            mtdm_pkg::ST_ROOT_WAIT:
            begin
                if (rsp.done)
                begin
                    if (item_reg.mask_weight)
                        sum_next = sum_reg +
                                   mtdm_pkg::SUM_W'(rsp.result[mtdm_pkg::DIST_W-1:0]);
                    count_next = count_reg + 1'b1;
                    state_next = mtdm_pkg::ST_TEMPLATE;
                end
            end
            mtdm_pkg::ST_TEMPLATE:
            begin
                if (item_reg.template_end || item_reg.center_end)
                begin
                    if (!rej_reg && (count_reg != '0))
                    begin
                        req.start   = 1'b1;
                        req.op      = mtdm_pkg::OP_DIV;
                        req.operand = sum_reg;
                        req.divisor = count_reg;
                        state_next  = mtdm_pkg::ST_DIV_WAIT;
                    end
                    else
                        state_next = mtdm_pkg::ST_TEMPLATE_DONE;
                end
                else
                    state_next = mtdm_pkg::ST_IDLE;
            end
            mtdm_pkg::ST_DIV_WAIT:
            begin
                if (rsp.done)
                begin
                    // strict compare keeps the earlier template on a tie
                    if (mean_dist < best_reg)
                    begin
                        best_next     = mean_dist;
                        best_idx_next = tmpl_reg;
                        found_next    = 1'b1;
                    end
                    state_next = mtdm_pkg::ST_TEMPLATE_DONE;
                end
            end
            mtdm_pkg::ST_TEMPLATE_DONE:
            begin
                if (tmpl_reg < mtdm_pkg::TMPL_W'(mtdm_pkg::TMPL_LAST))
                    tmpl_next = tmpl_reg + 1'b1;
                sum_next   = '0;
                count_next = '0;
                rej_next   = 1'b0;
                if (item_reg.center_end)
                    state_next = mtdm_pkg::ST_EMIT;
                else
                    state_next = mtdm_pkg::ST_IDLE;
            end
            mtdm_pkg::ST_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.best_distance = best_reg;
                    res_next.best_template = best_idx_reg;
                    res_next.found         = found_reg;
                    res_next.is_match      = found_reg && (best_reg < thr_reg);
                    res_valid_next         = 1'b1;
                    tmpl_next              = '0;
                    best_next              = mtdm_pkg::DIST_NONE;
                    best_idx_next          = '0;
                    found_next             = 1'b0;
                    state_next             = mtdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtdm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtdm_pkg::ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            rej_reg       <= 1'b0;
            tmpl_reg      <= '0;
            best_reg      <= mtdm_pkg::DIST_NONE;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            thr_reg       <= '0;
            res_valid_reg <= 1'b0;
            ch_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            rej_reg       <= rej_next;
            tmpl_reg      <= tmpl_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            ch_reg        <= ch_next;
            if (cfg_valid)
                thr_reg <= cfg_data;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/mtdm_shsub.sv @@
`default_nettype none

// Shared shift/compare/subtract unit, one result bit per cycle.
// Square root: two radicand bits shift in per step, trial is {root, 01}.
// Division: one dividend bit shifts in per step, trial is the divisor.
module mtdm_shsub
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mtdm_pkg::unit_req_t req,
    output mtdm_pkg::unit_rsp_t      rsp
);

    logic [mtdm_pkg::SUM_W-1:0]   src_reg,  src_next;
    logic [mtdm_pkg::SUM_W-1:0]   q_reg,    q_next;
    logic [mtdm_pkg::REM_W-1:0]   rem_reg,  rem_next;
    logic [mtdm_pkg::COUNT_W-1:0] div_reg;
    mtdm_pkg::op_t                op_reg;
    logic [mtdm_pkg::STEP_W-1:0]  cnt_reg,  cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [mtdm_pkg::REM_W-1:0]   cand;
    logic [mtdm_pkg::REM_W-1:0]   trial;
    logic                         ge;
    logic [mtdm_pkg::STEP_W-1:0]  last_step;

    // One iteration step
    always_comb
    begin
        if (op_reg == mtdm_pkg::OP_SQRT)
        begin
            cand      = {rem_reg[mtdm_pkg::REM_W-3:0], src_reg[mtdm_pkg::SUM_W-1 -: 2]};
            trial     = {q_reg[mtdm_pkg::REM_W-3:0], 2'b01};
            last_step = mtdm_pkg::STEP_W'(mtdm_pkg::SQRT_STEPS - 1);
        end
        else
        begin
            cand      = {rem_reg[mtdm_pkg::REM_W-2:0], src_reg[mtdm_pkg::SUM_W-1]};
            trial     = mtdm_pkg::REM_W'(div_reg);
            last_step = mtdm_pkg::STEP_W'(mtdm_pkg::DIV_STEPS - 1);
        end
        ge = (cand >= trial);
    end

    // Next-state of the iteration registers
    always_comb
    begin
        src_next  = src_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            src_next  = req.operand;
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (cand - trial) : cand;
            q_next   = {q_reg[mtdm_pkg::SUM_W-2:0], ge};
            if (op_reg == mtdm_pkg::OP_SQRT)
                src_next = {src_reg[mtdm_pkg::SUM_W-3:0], 2'b00};
            else
                src_next = {src_reg[mtdm_pkg::SUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            div_reg <= req.divisor;
            op_reg  <= req.op;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;

endmodule

`default_nettype wire

@@ rtl/core/mtdm_checker.sv @@
`default_nettype none

module mtdm_checker
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           pix_valid,
    input wire logic           pix_ready,
    input wire logic           res_valid,
    input wire logic           res_ready,
    input wire mtdm_pkg::res_t res
);

    // A stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // No valid template: distance none, index zero, no match
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |->
            res.best_distance == mtdm_pkg::DIST_NONE && res.best_template == '0
            && !res.is_match)
        else $error("empty result not in its cleared form");

    // A found template always beats the none distance
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> res.best_distance != mtdm_pkg::DIST_NONE)
        else $error("found result carries the none distance");

    // Pixel ready drops in the cycle after every accepted pixel
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel accepted on back-to-back cycles");

endmodule

bind masked_template_distance_min mtdm_checker u_mtdm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

@@ bench/tb.sv @@
module tb;
    import mtdm_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_PAIRS   = 190;
    localparam int REPORT_LIMIT  = 40;

    // Content styles for generated pixel pairs
    typedef enum int
    {
        MIX_RANDOM,
        MIX_EQUAL,
        MIX_NEAR,
        MIX_EXTREME
    } pair_mix_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              pix_valid = 1'b0;
    logic              pix_ready;
    pix_t              pix       = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_t              res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DIST_W-1:0] cfg_data  = '0;

    masked_template_distance_min DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Beats waiting to be sent, and best-match results still owed by the block
    pix_t pair_q[$];
    res_t best_match_q[$];
    int   pairs_queued = 0;
    int   err_count    = 0;
    int   cycle_count  = 0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;

    // Threshold as last written
    logic [DIST_W-1:0] match_thr = '0;

    // Search state: running template sums and the best template of the centre
    logic [SUM_W-1:0]   run_sum;
    logic [COUNT_W-1:0] run_count;
    logic               run_rejected;
    logic [TMPL_W-1:0]  tmpl_idx;
    logic [DIST_W-1:0]  best_dist;
    logic [TMPL_W-1:0]  best_tmpl;
    logic               any_found;

    task automatic clear_template();
        run_sum      = '0;
        run_count    = '0;
        run_rejected = 1'b0;
    endtask

    task automatic clear_center();
        clear_template();
        tmpl_idx  = '0;
        best_dist = DIST_NONE;
        best_tmpl = '0;
        any_found = 1'b0;
    endtask

    // Q9.4 colour distance: floor(sqrt(256 * sum of squared channel differences))
    function automatic logic [DIST_W-1:0] pair_distance(input pix_t p);
        int          dr, dg, db;
        int unsigned energy, root, trial;
        dr     = int'(p.image_red)   - int'(p.pattern_red);
        dg     = int'(p.image_green) - int'(p.pattern_green);
        db     = int'(p.image_blue)  - int'(p.pattern_blue);
        energy = (dr * dr + dg * dg + db * db) << 8;
        root   = 0;
        for (int b = 12; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= energy)
                root = trial;
        end
        return DIST_W'(root);
    endfunction

    // Fold one accepted pixel pair into the search; a centre end owes one result
    task automatic fold_pixel_pair(input pix_t p);
        int unsigned mean;
        res_t        outcome;
        if (p.window_rejected)
            run_rejected = 1'b1;
        if (p.inside_image && run_count < COUNT_LIMIT)
        begin
            if (p.mask_weight)
                run_sum = run_sum + pair_distance(p);
            run_count = run_count + 1'b1;
        end
        if (p.template_end || p.center_end)
        begin
            if (!run_rejected && run_count != 0)
            begin
                mean = 32'(run_sum) / 32'(run_count);
                if (mean > DIST_NONE)
                    mean = DIST_NONE;
                // strict compare keeps the earlier template on a tie
                if (mean < best_dist)
                begin
                    best_dist = DIST_W'(mean);
                    best_tmpl = tmpl_idx;
                    any_found = 1'b1;
                end
            end
            if (tmpl_idx < TMPL_LAST)
                tmpl_idx = tmpl_idx + 1'b1;
            clear_template();
        end
        if (p.center_end)
        begin
            outcome.best_distance = best_dist;
            outcome.best_template = best_tmpl;
            outcome.found         = any_found;
            outcome.is_match      = any_found && (best_dist < match_thr);
            best_match_q.push_back(outcome);
            clear_center();
        end
    endtask

    // Pixel driver: bursts of beats with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid  <= 1'b0;
            pix        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
            clear_center();
        end
        else
        begin
            if (pix_valid && pix_ready)
                fold_pixel_pair(pix);
            if (!pix_valid || pix_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    pix_valid <= 1'b0;
                end
                else if (pair_q.size() != 0)
                begin
                    pix       <= pair_q.pop_front();
                    pix_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : res_check
        res_t want;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (best_match_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("%0t: result with none expected, got %0d/%0d/%0b/%0b",
                                 $time, res.best_distance, res.best_template,
                                 res.found, res.is_match);
                end
                else
                begin
                    want = best_match_q.pop_front();
                    check_field("best_distance", 16'(want.best_distance),
                                16'(res.best_distance));
                    check_field("best_template", 16'(want.best_template),
                                16'(res.best_template));
                    check_field("found", 16'(want.found), 16'(res.found));
                    check_field("is_match", 16'(want.is_match), 16'(res.is_match));
                end
            end
            if (stall_left == 0)
            begin
                res_ready <= ~res_ready;
                if (res_ready)
                    stall_left <= $urandom_range(0, 40);
                else
                    stall_left <= ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(0, 30);
            end
            else
                stall_left <= stall_left - 1;
        end
    end

    // Cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("masked_template_distance_min test failed");
        $finish;
    end

    task automatic queue_pair(input pix_t p);
        pair_q.push_back(p);
        pairs_queued++;
    endtask

    function automatic pix_t make_pair(input logic [7:0] img, input logic [7:0] pat,
                                       input bit mask, input bit counted, input bit reject,
                                       input bit t_end, input bit c_end);
        pix_t p;
        p.image_red       = img;
        p.image_green     = img;
        p.image_blue      = img;
        p.pattern_red     = pat;
        p.pattern_green   = pat;
        p.pattern_blue    = pat;
        p.mask_weight     = mask;
        p.inside_image    = counted;
        p.window_rejected = reject;
        p.template_end    = t_end;
        p.center_end      = c_end;
        return p;
    endfunction

    function automatic logic [7:0] rail();
        return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    endfunction

    // Random channel content, flags left clear
    function automatic pix_t random_pair(input pair_mix_t mix);
        pix_t p;
        p               = '0;
        p.image_red     = 8'($urandom);
        p.image_green   = 8'($urandom);
        p.image_blue    = 8'($urandom);
        p.pattern_red   = 8'($urandom);
        p.pattern_green = 8'($urandom);
        p.pattern_blue  = 8'($urandom);
        case (mix)
            MIX_EQUAL:
            begin
                p.pattern_red   = p.image_red;
                p.pattern_green = p.image_green;
                p.pattern_blue  = p.image_blue;
            end
            MIX_NEAR:
            begin
                p.pattern_red   = p.image_red   + 8'($urandom_range(0, 6)) - 8'd3;
                p.pattern_green = p.image_green + 8'($urandom_range(0, 6)) - 8'd3;
                p.pattern_blue  = p.image_blue  + 8'($urandom_range(0, 6)) - 8'd3;
            end
            MIX_EXTREME:
            begin
                p.image_red     = rail();
                p.image_green   = rail();
                p.image_blue    = rail();
                p.pattern_red   = rail();
                p.pattern_green = rail();
                p.pattern_blue  = rail();
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // One well-formed centre: a run of templates, the last beat closing the centre
    task automatic queue_center(input int n_tmpl);
        int        n_pix, reject_at;
        bit        rejected, no_count, last, closing;
        pair_mix_t mix;
        pix_t      p;
        for (int t = 0; t < n_tmpl; t++)
        begin
            n_pix     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6);
            mix       = pair_mix_t'($urandom_range(0, 3));
            rejected  = ($urandom_range(0, 9) == 0);
            no_count  = ($urandom_range(0, 11) == 0);
            reject_at = $urandom_range(0, n_pix - 1);
            for (int i = 0; i < n_pix; i++)
            begin
                last              = (i == n_pix - 1);
                closing           = last && (t == n_tmpl - 1);
                p                 = random_pair(mix);
                p.mask_weight     = ($urandom_range(0, 7) != 0);
                p.inside_image    = !no_count && ($urandom_range(0, 7) != 0);
                p.window_rejected = rejected && (i == reject_at);
                // a centre end may also close the template on its own
                p.template_end    = last && (!closing || $urandom_range(0, 3) != 0);
                p.center_end      = closing;
                queue_pair(p);
            end
        end
    endtask

    // Mostly well-formed centres, some short runs of arbitrary beats
    task automatic run_random_phase(input int n_pairs);
        int   stop_at;
        pix_t p;
        stop_at = pairs_queued + n_pairs;
        while (pairs_queued < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    p = random_pair(MIX_RANDOM);
                    {p.mask_weight, p.inside_image, p.window_rejected,
                     p.template_end, p.center_end} = 5'($urandom);
                    queue_pair(p);
                end
                p = random_pair(MIX_RANDOM);
                {p.mask_weight, p.inside_image, p.window_rejected,
                 p.template_end} = 4'($urandom);
                p.center_end = 1'b1;
                queue_pair(p);
            end
            else
                queue_center(($urandom_range(0, 11) == 0) ? $urandom_range(15, 19)
                                                          : $urandom_range(1, 4));
        end
    endtask

    // Wait for every beat to go and every result to come back, then let the block settle
    task automatic drain_and_settle();
        while (pair_q.size() != 0 || pix_valid || best_match_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [DIST_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        match_thr = value;
    endtask

    // Stimulus
    initial
    begin
        logic [DIST_W-1:0] thr_plan [5];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_threshold(13'd4000);

        // zero distance, then full-scale both ways; second beat ends the centre only
        queue_pair(make_pair(8'd0,   8'd0,   1, 1, 0, 1, 1));
        queue_pair(make_pair(8'd255, 8'd0,   1, 1, 0, 0, 1));
        queue_pair(make_pair(8'd0,   8'd255, 1, 1, 0, 1, 1));
        // rejected window cannot win even with zero distance
        queue_pair(make_pair(8'd9,   8'd9,   1, 1, 1, 1, 0));
        queue_pair(make_pair(8'd0,   8'd40,  1, 1, 0, 1, 1));
        // nothing counted: no valid template
        queue_pair(make_pair(8'd200, 8'd3,   1, 0, 0, 0, 1));
        // tie, earlier template kept
        queue_pair(make_pair(8'd30,  8'd10,  1, 1, 0, 1, 0));
        queue_pair(make_pair(8'd10,  8'd30,  1, 1, 0, 1, 1));
        // masked-off pixels add nothing
        queue_pair(make_pair(8'd255, 8'd0,   0, 1, 0, 0, 0));
        queue_pair(make_pair(8'd0,   8'd255, 0, 1, 0, 1, 1));
        // more templates than the index holds; the last one is best
        for (int t = 0; t <= 16; t++)
            queue_pair(make_pair(8'(200 - 10 * t), 8'd0, 1, 1, 0, 1, t == 16));

        // random phases over a spread of thresholds, extremes included
        thr_plan = '{13'd8191, 13'd0, 13'($urandom_range(1, 3000)), 13'd1,
                     13'($urandom_range(0, 8191))};
        foreach (thr_plan[k])
        begin
            drain_and_settle();
            write_threshold(thr_plan[k]);
            run_random_phase(PHASE_PAIRS);
        end

        drain_and_settle();
        if (err_count == 0)
            $display("masked_template_distance_min test passed");
        else
            $display("masked_template_distance_min test failed");
        $finish;
    end

endmodule
